[design/its_pkg.sv]
// Shared types and constants for the interval time statistics block.
package its_pkg;

   localparam int REQ_DATA_WIDTH = 32;
   localparam int FIELD_WIDTH    = 32;
   localparam int RSP_DATA_WIDTH = 5 * FIELD_WIDTH;
   localparam int SUM_WIDTH      = 64;
   localparam int COUNT_WIDTH    = 32;
   localparam int DIV_STEPS      = SUM_WIDTH;
   localparam int STEP_WIDTH     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_BEGIN    = 2'd1,
      OP_END      = 2'd2,
      OP_INTERVAL = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIVIDE,
      ST_MEAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic mean_load;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic counted;
      logic div_last;
   } status_type;

endpackage

[design/its_ctrl.sv]
// Sequencer for the interval time statistics block and the result valid flag.
module its_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output its_pkg::cmd_type    cmd,
   input  its_pkg::status_type status
);
   import its_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.counted ? ST_DIVIDE : ST_RESULT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            cmd.mean_load = 1'b1;
            state_in      = ST_RESULT;
         end
         ST_RESULT: begin
            // The output register takes the result once its previous one is gone.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start execution");

   a_divide_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && !status.div_last) |=> (state_ff == ST_DIVIDE))
      else $error("divider left before its last step");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid)
      else $error("result load did not raise valid");
`endif

endmodule

[design/its_dpath.sv]
// Statistics registers, sequential divider and output register of the profiler.
module its_dpath #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [1:0]                          req_opcode,
   input  logic [its_pkg::REQ_DATA_WIDTH-1:0]  req_timestamp,
   input  its_pkg::cmd_type                    cmd,
   output its_pkg::status_type                 status,
   output logic                                rsp_counted,
   output logic [its_pkg::RSP_DATA_WIDTH-1:0]  rsp_data
);
   import its_pkg::*;

   localparam logic [SUM_WIDTH-1:0] MeanMax = SUM_WIDTH'({TIME_WIDTH{1'b1}});

   opcode_type             op_ff, op_in;
   logic [TIME_WIDTH-1:0]  now_ff, now_in;
   logic [TIME_WIDTH-1:0]  start_ff, start_in;
   logic [TIME_WIDTH-1:0]  interval_ff, interval_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [TIME_WIDTH-1:0]  mean_ff, mean_in;
   logic [TIME_WIDTH-1:0]  max_ff, max_in;
   logic [TIME_WIDTH-1:0]  min_ff, min_in;
   logic                   counted_ff, counted_in;
   logic [SUM_WIDTH-1:0]   quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_in;
   logic [COUNT_WIDTH-1:0] divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0]  step_ff, step_in;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic                   out_counted_ff, out_counted_in;

   logic [TIME_WIDTH-1:0]  interval_new;
   logic [SUM_WIDTH:0]     sum_wide;
   logic [SUM_WIDTH-1:0]   sum_next;
   logic [COUNT_WIDTH-1:0] count_next;
   logic                   counted_now;
   logic [COUNT_WIDTH:0]   rem_shift;
   logic [COUNT_WIDTH:0]   rem_diff;

   assign interval_new = now_ff - start_ff;
   assign sum_wide     = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(interval_new);
   assign sum_next     = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
   assign count_next   = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   // A start at timestamp zero is indistinguishable from no start at all.
   assign counted_now  = ((op_ff == OP_END) || (op_ff == OP_INTERVAL)) && (start_ff != '0);

   // Restoring division: one quotient bit per cycle shifts into the dividend register.
   assign rem_shift = {rem_ff, quo_ff[SUM_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};

   assign status.counted  = counted_now;
   assign status.div_last = (step_ff == STEP_WIDTH'(DIV_STEPS - 1));

   always_comb begin
      op_in          = op_ff;
      now_in         = now_ff;
      start_in       = start_ff;
      interval_in    = interval_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      mean_in        = mean_ff;
      max_in         = max_ff;
      min_in         = min_ff;
      counted_in     = counted_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      divisor_in     = divisor_ff;
      step_in        = step_ff;
      out_data_in    = out_data_ff;
      out_counted_in = out_counted_ff;

      if (cmd.capture) begin
         op_in  = opcode_type'(req_opcode);
         now_in = TIME_WIDTH'(req_timestamp);
      end

      if (cmd.exec) begin
         counted_in = counted_now;
         case (op_ff)
            OP_CLEAR: begin
               start_in    = '0;
               interval_in = '0;
               sum_in      = '0;
               count_in    = '0;
               mean_in     = '0;
               max_in      = '0;
               min_in      = '1;
            end
            OP_BEGIN: begin
               start_in = now_ff;
            end
            OP_END, OP_INTERVAL: begin
               interval_in = interval_new;
               if (counted_now) begin
                  sum_in     = sum_next;
                  count_in   = count_next;
                  max_in     = (interval_new > max_ff) ? interval_new : max_ff;
                  min_in     = (interval_new < min_ff) ? interval_new : min_ff;
                  quo_in     = sum_next;
                  divisor_in = count_next;
                  rem_in     = '0;
                  step_in    = '0;
               end
               if (op_ff == OP_INTERVAL) begin
                  start_in = now_ff;
               end
            end
            default: begin
               start_in = start_ff;
            end
         endcase
      end

      if (cmd.div_step) begin
         if (!rem_diff[COUNT_WIDTH]) begin
            rem_in = rem_diff[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[COUNT_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
      end

      if (cmd.mean_load) begin
         mean_in = (quo_ff > MeanMax) ? TIME_WIDTH'(MeanMax) : TIME_WIDTH'(quo_ff);
      end

      if (cmd.out_load) begin
         out_counted_in = counted_ff;
         out_data_in    = {FIELD_WIDTH'(count_ff), FIELD_WIDTH'(max_ff),
                           FIELD_WIDTH'(min_ff), FIELD_WIDTH'(mean_ff),
                           FIELD_WIDTH'(interval_ff)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= '0;
         interval_ff <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         mean_ff     <= '0;
         max_ff      <= '0;
         min_ff      <= '1;
         counted_ff  <= 1'b0;
         step_ff     <= '0;
      end else begin
         start_ff    <= start_in;
         interval_ff <= interval_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
         mean_ff     <= mean_in;
         max_ff      <= max_in;
         min_ff      <= min_in;
         counted_ff  <= counted_in;
         step_ff     <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      now_ff         <= now_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      divisor_ff     <= divisor_in;
      out_data_ff    <= out_data_in;
      out_counted_ff <= out_counted_in;
   end

   assign rsp_counted = out_counted_ff;
   assign rsp_data    = out_data_ff;

`ifndef SYNTHESIS
   a_min_below_max: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (min_ff <= max_ff))
      else $error("minimum exceeds maximum with samples present");

   a_empty_stats: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum_ff == '0 && max_ff == '0 && min_ff == '1))
      else $error("statistics not at reset value without samples");

   a_quiet_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !counted_now && op_ff != OP_CLEAR) |=> (count_ff == $past(count_ff)))
      else $error("sample count moved on a request that added no sample");
`endif

endmodule

[design/interval_time_statistics_top.sv]
// Top level of the interval time statistics profiler.
//
//  Channel   Direction  Handshake              Payload
//  req_      in         req_tvalid/req_tready  tuser: opcode, tdata: timestamp
//  rsp_      out        rsp_tvalid/rsp_tready  tuser: counted, tdata: statistics
//
// Clear, begin and any end that adds no sample are accepted, executed and have their
// result loaded. An end or interval request that adds a sample also passes the
// divide and mean steps: the average comes from a restoring divider that yields
// one of 64 quotient bits a cycle. One request is worked on at a time; the next
// is accepted while the output register still holds the previous result, but a
// new result waits for that one to be taken and no request is accepted meanwhile.
// Reset is synchronous, active high, and returns all statistics to their cleared values at once.
module interval_time_statistics_top #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata = timestamp[31:0]
   input  logic [its_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // tuser = opcode[1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata = last_interval[31:0], average[63:32], minimum[95:64],
   //         maximum[127:96], sample_count[159:128]
   output logic [its_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // tuser = counted
   output logic                                rsp_tuser
);
   import its_pkg::*;

   cmd_type    cmd;
   status_type status;

   its_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   its_dpath #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_opcode    (req_tuser),
      .req_timestamp (req_tdata),
      .cmd           (cmd),
      .status        (status),
      .rsp_counted   (rsp_tuser),
      .rsp_data      (rsp_tdata)
   );

endmodule

[tb/interval_stats_checker.sv]
// Checker that predicts the profiler's statistics and compares every result.
`timescale 1ns / 100ps

module interval_stats_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [its_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  logic [1:0]                         req_tuser,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [its_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                               rsp_tuser,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 checked_count,
   output int                                 sample_count
);
   import its_pkg::*;

   localparam logic [63:0] SUM_LIMIT   = '1;
   localparam logic [31:0] COUNT_LIMIT = '1;
   localparam logic [31:0] TIME_LIMIT  = '1;

   typedef struct packed {
      logic        counted;
      logic [31:0] last_interval;
      logic [31:0] average;
      logic [31:0] minimum;
      logic [31:0] maximum;
      logic [31:0] sample_count;
   } stats_type;

   // Shadow copy of the profiler state.
   logic [31:0] start_mark;
   logic [31:0] last_interval;
   logic [63:0] interval_sum;
   logic [31:0] interval_count;
   logic [31:0] mean_value;
   logic [31:0] min_interval;
   logic [31:0] max_interval;

   stats_type pending_stats[$];
   int        errors;
   int        checks;
   int        samples;

   function automatic void clear_stats();
      start_mark     = '0;
      last_interval  = '0;
      interval_sum   = '0;
      interval_count = '0;
      mean_value     = '0;
      max_interval   = '0;
      min_interval   = TIME_LIMIT;
   endfunction

   function automatic stats_type profile_request(opcode_type op, logic [31:0] stamp);
      stats_type   r;
      logic        took;
      logic [63:0] quotient;
      took = 1'b0;
      case (op)
         OP_CLEAR: clear_stats();
         OP_BEGIN: start_mark = stamp;
         default: begin
            // The elapsed time wraps modulo 2^32 with the free-running counter.
            last_interval = stamp - start_mark;
            if (start_mark != '0) begin
               took = 1'b1;
               if (interval_sum > SUM_LIMIT - {32'd0, last_interval})
                  interval_sum = SUM_LIMIT;
               else
                  interval_sum = interval_sum + {32'd0, last_interval};
               if (interval_count != COUNT_LIMIT)
                  interval_count = interval_count + 1'b1;
               quotient = interval_sum / {32'd0, interval_count};
               mean_value = (quotient > {32'd0, TIME_LIMIT}) ? TIME_LIMIT : quotient[31:0];
               if (last_interval > max_interval)
                  max_interval = last_interval;
               if (last_interval < min_interval)
                  min_interval = last_interval;
            end
            if (op == OP_INTERVAL)
               start_mark = stamp;
         end
      endcase
      r.counted       = took;
      r.last_interval = last_interval;
      r.average       = mean_value;
      r.minimum       = min_interval;
      r.maximum       = max_interval;
      r.sample_count  = interval_count;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : watch
      stats_type seen;
      stats_type want;
      if (reset) begin
         clear_stats();
         pending_stats.delete();
      end else begin
         if (req_tvalid && req_tready)
            pending_stats.push_back(profile_request(opcode_type'(req_tuser), req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            seen.counted       = rsp_tuser;
            seen.last_interval = rsp_tdata[31:0];
            seen.average       = rsp_tdata[63:32];
            seen.minimum       = rsp_tdata[95:64];
            seen.maximum       = rsp_tdata[127:96];
            seen.sample_count  = rsp_tdata[159:128];
            checks++;
            if (seen.counted === 1'b1)
               samples++;
            if (pending_stats.size() == 0) begin
               $display("%0t ns: result with no request waiting, actual %h", $time, seen);
               errors++;
            end else begin
               want = pending_stats.pop_front();
               check_field("counted", {31'd0, want.counted}, {31'd0, seen.counted});
               check_field("last_interval", want.last_interval, seen.last_interval);
               check_field("average", want.average, seen.average);
               check_field("minimum", want.minimum, seen.minimum);
               check_field("maximum", want.maximum, seen.maximum);
               check_field("sample_count", want.sample_count, seen.sample_count);
            end
         end
      end
      fail_count    <= errors;
      pending_count <= pending_stats.size();
      checked_count <= checks;
      sample_count  <= samples;
   end

endmodule

[tb/interval_time_statistics_top_tb.sv]
// Top of the profiler testbench: clock, reset, request and result traffic, verdict.
`timescale 1ns / 100ps

module interval_time_statistics_top_tb;
   import its_pkg::*;

   localparam int REQUEST_TOTAL = 1300;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 300;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;
   logic [1:0]                req_tuser;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tuser;

   int fail_count;
   int pending_count;
   int checked_count;
   int sample_count;

   int          sent;
   int          send_calm;
   logic [31:0] now_stamp;

   interval_time_statistics_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   interval_stats_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .sample_count  (sample_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results still outstanding.", pending_count);
      $display("*** FAILED ***");
      $finish;
   end

   task automatic send(opcode_type op, logic [31:0] stamp);
      int gap;
      gap = (send_calm > 0) ? 0 : $urandom_range(0, 8);
      if (send_calm > 0)
         send_calm--;
      else if ($urandom_range(0, 31) == 0)
         send_calm = 30;
      if (gap > 0) begin
         // Junk on the idle bus must be ignored.
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;
         req_tuser  <= 2'($urandom_range(0, 3));
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   function automatic logic [31:0] pick_delta();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 15);
         1:       return $urandom_range(0, 4095);
         2:       return $urandom_range(0, 1 << 20);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_measurements();
      int runs;
      if ($urandom_range(0, 9) < 3)
         now_stamp = $urandom;
      // A start at time zero must count as no start at all.
      send(OP_BEGIN, ($urandom_range(0, 19) == 0) ? 32'd0 : now_stamp);
      runs = $urandom_range(1, 12);
      for (int i = 0; i < runs; i++) begin
         now_stamp = now_stamp + pick_delta();
         send(($urandom_range(0, 1) == 0) ? OP_END : OP_INTERVAL, now_stamp);
      end
   endtask

   // Stimulus: directed corner cases, then mostly well-formed measurement runs.
   initial begin
      int choice;
      int noise;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= OP_CLEAR;
      sent       = 0;
      send_calm  = 0;
      now_stamp  = $urandom;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send(OP_END, 32'd100);
      send(OP_BEGIN, 32'd0);
      send(OP_END, 32'd50);
      send(OP_INTERVAL, 32'd70);
      send(OP_END, 32'd70);
      send(OP_END, 32'd69);
      send(OP_BEGIN, 32'hFFFF_FFFF);
      send(OP_END, 32'h0000_0010);
      send(OP_INTERVAL, 32'h0000_1010);
      send(OP_INTERVAL, 32'h0000_1110);
      send(OP_END, 32'h0000_1111);
      send(OP_END, 32'h0000_1120);
      send(OP_CLEAR, 32'hFFFF_FFFF);
      send(OP_END, 32'd5);
      send(OP_BEGIN, 32'h8000_0000);
      send(OP_END, 32'h7FFF_FFFF);
      send(OP_CLEAR, 32'd0);
      send(OP_BEGIN, 32'd1);
      send(OP_END, 32'd0);
      send(OP_BEGIN, 32'hFFFF_FFFF);
      send(OP_END, 32'hFFFF_FFFF);
      send(OP_CLEAR, 32'hA5A5_A5A5);

      while (sent < REQUEST_TOTAL) begin
         choice = $urandom_range(0, 99);
         if (choice < 80) begin
            run_measurements();
         end else if (choice < 88) begin
            send(OP_CLEAR, $urandom);
            if ($urandom_range(0, 1) == 0)
               send(($urandom_range(0, 1) == 0) ? OP_END : OP_INTERVAL, $urandom);
         end else begin
            noise = $urandom_range(1, 4);
            for (int i = 0; i < noise; i++)
               send(opcode_type'($urandom_range(0, 3)), $urandom);
         end
      end
      req_tvalid <= 1'b0;

      for (int waited = 0; pending_count != 0 && waited < 5000; waited++)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_count != 0)
         $display("%0t ns: %0d expected results never arrived", $time, pending_count);

      $display("Sent %0d requests; %0d results checked, %0d of them added a sample.",
               sent, checked_count, sample_count);
      $display("Covered clear, begin, end and interval with zero, wrapped and full-range ",
               "intervals under random stalls and a long output hold.");
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches found.", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Result side: random stalls, calm stretches, and two long holds that back up the input.
   initial begin
      int gap;
      int taken;
      int calm;
      rsp_tready <= 1'b0;
      taken = 0;
      calm  = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken == 60 || taken == 700)
            gap = HOLD_CYCLES;
         else
            gap = (calm > 0) ? 0 : $urandom_range(0, 8);
         if (calm > 0)
            calm--;
         else if ($urandom_range(0, 31) == 0)
            calm = 30;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         taken++;
      end
   end

endmodule
